/* src/wsfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wsfp_pkg;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_LEN,
        PH_EXT,
        PH_KEY,
        PH_DATA
    } phase_t;

    typedef logic [2:0] action_t;

    localparam action_t ACT_NONE      = 3'd0;
    localparam action_t ACT_MSG_DONE  = 3'd1;
    localparam action_t ACT_FRAGMENT  = 3'd2;
    localparam action_t ACT_CLOSE     = 3'd3;
    localparam action_t ACT_PONG_TX   = 3'd4;
    localparam action_t ACT_PONG_SEEN = 3'd5;
    localparam action_t ACT_ERROR     = 3'd6;

    localparam logic [3:0] OP_DATA_MAX = 4'h7;
    localparam logic [3:0] OP_CLOSE    = 4'h8;
    localparam logic [3:0] OP_PING     = 4'h9;
    localparam logic [3:0] OP_PONG     = 4'hA;

    localparam logic [6:0] LEN_CODE_MAX = 7'h7D;
    localparam logic [6:0] LEN_CODE_16  = 7'h7E;

    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;

    typedef struct packed {
        logic       has_data;
        logic [7:0] data_byte;
        logic       frame_end;
        logic [3:0] frame_opcode;
        logic       frame_fin;
        action_t    action;
    } result_t;

    function automatic action_t end_action(input logic [3:0] opcode, input logic fin);
        action_t act;
        if (opcode <= OP_DATA_MAX) begin
            act = fin ? ACT_MSG_DONE : ACT_FRAGMENT;
        end
        else if (opcode == OP_CLOSE) begin
            act = ACT_CLOSE;
        end
        else if (opcode == OP_PING) begin
            act = ACT_PONG_TX;
        end
        else if (opcode == OP_PONG) begin
            act = ACT_PONG_SEEN;
        end
        else begin
            act = ACT_ERROR;
        end
        return act;
    endfunction

endpackage

`default_nettype wire

/* src/wsfp_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface wsfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* src/wsfp_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface wsfp_out_if;
    logic       valid;
    logic       ready;
    logic       has_data;
    logic [7:0] data_byte;
    logic       frame_end;
    logic [3:0] frame_opcode;
    logic       frame_fin;
    logic [2:0] action;

    modport source (output valid, output has_data, output data_byte, output frame_end,
                    output frame_opcode, output frame_fin, output action, input ready);
    modport sink (input valid, input has_data, input data_byte, input frame_end,
                  input frame_opcode, input frame_fin, input action, output ready);
endinterface

`default_nettype wire

/* src/wsfp_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module wsfp_parser #(
    parameter int LENGTH_WIDTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        rx_byte,
    output logic                   res_valid,
    output wsfp_pkg::result_t      res
);
    import wsfp_pkg::*;

    phase_t                    phase_reg, phase_next;
    logic                      stopped_reg, stopped_next;
    logic                      fin_reg, fin_next;
    logic [3:0]                opcode_reg, opcode_next;
    logic                      masked_reg, masked_next;
    logic [3:0]                ext_left_reg, ext_left_next;
    logic [LENGTH_WIDTH-1:0]   len_reg, len_next;
    logic [31:0]               key_reg, key_next;
    logic [1:0]                pos_reg, pos_next;
    logic [LENGTH_WIDTH-1:0]   done_reg, done_next;

    logic                      len_known;
    logic [LENGTH_WIDTH-1:0]   known_len;
    logic                      frame_done;
    logic [7:0]                key_byte;
    logic [LENGTH_WIDTH-1:0]   done_inc;
    action_t                   act;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg    <= PH_HDR;
            stopped_reg  <= 1'b0;
            fin_reg      <= 1'b0;
            opcode_reg   <= '0;
            masked_reg   <= 1'b0;
            ext_left_reg <= '0;
            len_reg      <= '0;
            key_reg      <= '0;
            pos_reg      <= '0;
            done_reg     <= '0;
        end
        else if (accept) begin
            phase_reg    <= phase_next;
            stopped_reg  <= stopped_next;
            fin_reg      <= fin_next;
            opcode_reg   <= opcode_next;
            masked_reg   <= masked_next;
            ext_left_reg <= ext_left_next;
            len_reg      <= len_next;
            key_reg      <= key_next;
            pos_reg      <= pos_next;
            done_reg     <= done_next;
        end
    end

    always_comb begin
        case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign done_inc = done_reg + LENGTH_WIDTH'(1);
    assign act      = end_action(opcode_reg, fin_reg);

    always_comb begin
        phase_next    = phase_reg;
        stopped_next  = stopped_reg;
        fin_next      = fin_reg;
        opcode_next   = opcode_reg;
        masked_next   = masked_reg;
        ext_left_next = ext_left_reg;
        len_next      = len_reg;
        key_next      = key_reg;
        pos_next      = pos_reg;
        done_next     = done_reg;
        len_known     = 1'b0;
        known_len     = len_reg;
        frame_done    = 1'b0;
        res_valid     = 1'b0;
        res           = '0;
        res.frame_opcode = opcode_reg;
        res.frame_fin    = fin_reg;

        if (!stopped_reg) begin
            unique case (phase_reg)
                PH_HDR: begin
                    fin_next    = rx_byte[7];
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_LEN;
                end
                PH_LEN: begin
                    masked_next = rx_byte[7];
                    if (rx_byte[6:0] <= LEN_CODE_MAX) begin
                        len_known = 1'b1;
                        known_len = LENGTH_WIDTH'(rx_byte[6:0]);
                    end
                    else begin
                        ext_left_next = (rx_byte[6:0] == LEN_CODE_16) ? EXT_BYTES_16
                                                                      : EXT_BYTES_64;
                        len_next      = '0;
                        phase_next    = PH_EXT;
                    end
                end
                PH_EXT: begin
                    len_next      = {len_reg[LENGTH_WIDTH-9:0], rx_byte};
                    ext_left_next = ext_left_reg - 4'd1;
                    if (ext_left_next == 4'd0) begin
                        len_known = 1'b1;
                        known_len = len_next;
                    end
                end
                PH_KEY: begin
                    key_next = {key_reg[23:0], rx_byte};
                    pos_next = pos_reg + 2'd1;
                    if (pos_next == 2'd0) begin
                        if (len_reg == '0) begin
                            frame_done = 1'b1;
                        end
                        else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    res_valid     = 1'b1;
                    res.has_data  = 1'b1;
                    res.data_byte = masked_reg ? (rx_byte ^ key_byte) : rx_byte;
                    pos_next      = pos_reg + 2'd1;
                    done_next     = done_inc;
                    frame_done    = (done_inc == len_reg);
                end
                default: begin
                    phase_next = PH_HDR;
                end
            endcase

            if (len_known) begin
                len_next  = known_len;
                pos_next  = '0;
                done_next = '0;
                if (masked_next) begin
                    phase_next = PH_KEY;
                end
                else if (known_len == '0) begin
                    frame_done = 1'b1;
                end
                else begin
                    phase_next = PH_DATA;
                end
            end

            if (frame_done) begin
                res_valid     = 1'b1;
                res.frame_end = 1'b1;
                res.action    = act;
                if (act == ACT_CLOSE || act == ACT_ERROR) begin
                    stopped_next = 1'b1;
                end
                phase_next    = PH_HDR;
                fin_next      = 1'b0;
                opcode_next   = '0;
                masked_next   = 1'b0;
                ext_left_next = '0;
                len_next      = '0;
                key_next      = '0;
                pos_next      = '0;
                done_next     = '0;
            end
        end
    end

endmodule

`default_nettype wire

/* src/websocket_frame_parser_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial WebSocket frame deframer. One received byte is taken per clock
// cycle; its result word, if it has one, shows on the result channel the next
// cycle from a single output register. Header bytes give no word, except the
// byte that completes the header of an empty frame, which gives one word with
// frame_end set and no data. Each payload byte gives one unmasked data word; the
// last one carries frame_end and the frame's action. A new byte is taken in
// every cycle in which the output register is empty or being drained, so the
// sustained rate is one byte per cycle, set by the one-word output register.
// After a close or error action all bytes are taken and dropped until reset.
// LENGTH_WIDTH sets how many low bits of the payload length are kept.
module websocket_frame_parser_top #(
    parameter int LENGTH_WIDTH = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    wsfp_in_if.sink   rx,
    wsfp_out_if.source result
);
    import wsfp_pkg::*;

    logic     accept;
    logic     res_valid;
    result_t  res;
    logic     out_valid_reg, out_valid_next;
    result_t  out_reg;

    assign rx.ready = !out_valid_reg || result.ready;
    assign accept   = rx.valid && rx.ready;

    wsfp_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (result.ready) begin
            out_valid_next = 1'b0;
        end
        if (accept && res_valid) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept && res_valid) begin
            out_reg <= res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.has_data     = out_reg.has_data;
    assign result.data_byte    = out_reg.data_byte;
    assign result.frame_end    = out_reg.frame_end;
    assign result.frame_opcode = out_reg.frame_opcode;
    assign result.frame_fin    = out_reg.frame_fin;
    assign result.action       = out_reg.action;

endmodule

`default_nettype wire

/* src/wsfp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module wsfp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       has_data,
    input wire logic [7:0] data_byte,
    input wire logic       frame_end,
    input wire logic [2:0] action
);
    import wsfp_pkg::*;

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(data_byte))
        else $error("result data changed while stalled");

    a_end_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_end == (action != ACT_NONE)))
        else $error("action does not match frame end");

    a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_data |-> (data_byte == 8'd0) && frame_end)
        else $error("word without data is not a clean frame end");

    a_stop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (action == ACT_CLOSE || action == ACT_ERROR)
        |=> !out_valid)
        else $error("result after close or error");

endmodule

bind websocket_frame_parser_top wsfp_checker u_wsfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .has_data  (result.has_data),
    .data_byte (result.data_byte),
    .frame_end (result.frame_end),
    .action    (result.action)
);

`default_nettype wire
